### rtl/core/slcan_ascii_frame_parser_macros.svh
// Assertion macros used by the serial-line CAN parser checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef SLCAN_ASCII_FRAME_PARSER_MACROS_SVH
`define SLCAN_ASCII_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLCAN_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SLCAN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/core/slcan_pkg.sv
// Types, character codes and the hex digit decoder of the serial-line CAN parser.
// Depends on nothing; used by the parser top level and its checker.
package slcan_pkg;

    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_BEL       = 8'h07;
    localparam logic [7:0] BUS_DIGIT_BASE = 8'h30;
    localparam logic [7:0] CHAR_T_LOWER   = 8'h74;
    localparam logic [7:0] CHAR_T_UPPER   = 8'h54;
    localparam logic [7:0] CHAR_R_LOWER   = 8'h72;
    localparam logic [7:0] CHAR_R_UPPER   = 8'h52;
    localparam logic [7:0] CHAR_DIG_0     = 8'h30;
    localparam logic [7:0] CHAR_DIG_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A      = 8'h41;
    localparam logic [7:0] CHAR_UC_F      = 8'h46;
    localparam logic [7:0] CHAR_LC_A      = 8'h61;
    localparam logic [7:0] CHAR_LC_F      = 8'h66;

    localparam int STD_ID_DIGITS  = 3;
    localparam int EXT_ID_DIGITS  = 8;
    localparam int MAX_DATA_BYTES = 8;

    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_ACK      = 2'd1;
    localparam logic [1:0] KIND_BELL     = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic CFG_EXT_ENABLE  = 1'b0;
    localparam logic CFG_PREFIX_CHAR = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] can_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  data_len;
        logic [63:0] payload;
        logic [3:0]  bus_number;
        logic        format_error;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r = '0;
        if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            r.value = 4'(c - CHAR_DIG_0);
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            r.value = 4'(c - CHAR_UC_A + 8'd10);
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            r.value = 4'(c - CHAR_LC_A + 8'd10);
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/core/slcan_ascii_frame_parser.sv
// Serial-line CAN receive parser: ASCII characters in, frame/ack/error results out.
// Depends on slcan_pkg; checked by slcan_checker.
//
// Accepts one received character per clock while s_ready is high and updates its line
// state in the same cycle; an m_ result is registered from the character that ends
// the line (carriage return, bell, or a character past MAX_LINE). Results pass through
// an output register backed by one skid entry, so s_ready only drops while both hold a
// beat that the sink has not taken. Configuration writes are expected between lines.
module slcan_ascii_frame_parser #(
    parameter int MAX_LINE = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_result_kind,
    output logic [28:0]          m_can_id,
    output logic                 m_is_extended,
    output logic                 m_is_remote,
    output logic [3:0]           m_data_len,
    output logic [63:0]          m_payload,
    output logic [3:0]           m_bus_number,
    output logic                 m_format_error
);
    import slcan_pkg::*;

    localparam int PW = $clog2(MAX_LINE + 1);

    localparam logic [2:0] CMD_IDLE     = 3'd0;
    localparam logic [2:0] CMD_STD_DATA = 3'd1;
    localparam logic [2:0] CMD_EXT_DATA = 3'd2;
    localparam logic [2:0] CMD_STD_RMT  = 3'd3;
    localparam logic [2:0] CMD_EXT_RMT  = 3'd4;
    localparam logic [2:0] CMD_OTHER    = 3'd5;
    localparam logic [2:0] CMD_PREFIX   = 3'd6;
    localparam logic [2:0] CMD_BUS      = 3'd7;

    logic          ext_en_reg;
    logic [7:0]    prefix_char_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [3:0]    bus_reg, bus_next;
    logic [31:0]   id_reg, id_next;
    logic [3:0]    dlen_reg, dlen_next;
    logic [63:0]   payload_reg, payload_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          err_reg, err_next;
    logic          prefix_seen_reg, prefix_seen_next;

    result_t       res_next;
    logic          res_valid_next;
    result_t       out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;

    logic          accept;
    logic          is_frame_cmd;
    logic          is_ext_cmd;
    logic [PW-1:0] off;
    logic [PW-1:0] id_digits;
    hex_t          hex;
    logic [3:0]    nbytes;
    logic [7:0]    bus_diff;
    logic [3:0]    nib_idx;

    assign accept       = s_valid && s_ready;
    assign s_ready      = !skid_valid_reg;
    assign is_frame_cmd = (cmd_reg == CMD_STD_DATA) || (cmd_reg == CMD_EXT_DATA) ||
                          (cmd_reg == CMD_STD_RMT)  || (cmd_reg == CMD_EXT_RMT);
    assign is_ext_cmd   = (cmd_reg == CMD_EXT_DATA) || (cmd_reg == CMD_EXT_RMT);
    assign off          = prefix_seen_reg ? pos_reg - PW'(2) : pos_reg;
    assign id_digits    = is_ext_cmd ? PW'(EXT_ID_DIGITS) : PW'(STD_ID_DIGITS);
    assign hex          = hex_decode(s_rx_byte);
    assign nbytes       = cnt_reg[4:1];
    assign bus_diff     = s_rx_byte - BUS_DIGIT_BASE;
    assign nib_idx      = {cnt_reg[3:1], ~cnt_reg[0]};

    always_comb begin
        pos_next         = pos_reg;
        cmd_next         = cmd_reg;
        bus_next         = bus_reg;
        id_next          = id_reg;
        dlen_next        = dlen_reg;
        payload_next     = payload_reg;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        prefix_seen_next = prefix_seen_reg;
        res_next         = '0;
        res_valid_next   = 1'b0;

        priority if (s_rx_byte == CHAR_CR || s_rx_byte == CHAR_BEL ||
                     pos_reg >= PW'(MAX_LINE)) begin
            res_valid_next = 1'b1;
            if (s_rx_byte == CHAR_CR) begin
                if (is_frame_cmd) begin
                    res_next.kind         = KIND_FRAME;
                    res_next.can_id       = id_reg[28:0];
                    res_next.is_extended  = is_ext_cmd;
                    res_next.is_remote    = (cmd_reg == CMD_STD_RMT) ||
                                            (cmd_reg == CMD_EXT_RMT);
                    res_next.data_len     = nbytes;
                    res_next.bus_number   = bus_reg;
                    res_next.format_error = err_reg || (id_reg[31:29] != 3'd0);
                    for (int j = 0; j < MAX_DATA_BYTES; j++) begin
                        res_next.payload[j*8 +: 8] =
                            (4'(j) < nbytes) ? payload_reg[j*8 +: 8] : 8'd0;
                    end
                end else begin
                    res_next.kind = KIND_ACK;
                end
            end else if (s_rx_byte == CHAR_BEL) begin
                res_next.kind = KIND_BELL;
            end else begin
                res_next.kind = KIND_OVERFLOW;
            end
            pos_next         = '0;
            cmd_next         = CMD_IDLE;
            bus_next         = '0;
            id_next          = '0;
            dlen_next        = '0;
            payload_next     = '0;
            cnt_next         = '0;
            err_next         = 1'b0;
            prefix_seen_next = 1'b0;
        end else begin
            pos_next = pos_reg + PW'(1);
            priority if (pos_reg == '0 && ext_en_reg && s_rx_byte == prefix_char_reg) begin
                prefix_seen_next = 1'b1;
                cmd_next         = CMD_PREFIX;
            end else if (cmd_reg == CMD_PREFIX) begin
                bus_next = bus_diff[3:0];
                cmd_next = CMD_BUS;
            end else if (cmd_reg == CMD_IDLE || cmd_reg == CMD_BUS) begin
                priority if (s_rx_byte == CHAR_T_LOWER) cmd_next = CMD_STD_DATA;
                else if (s_rx_byte == CHAR_T_UPPER)     cmd_next = CMD_EXT_DATA;
                else if (s_rx_byte == CHAR_R_LOWER)     cmd_next = CMD_STD_RMT;
                else if (s_rx_byte == CHAR_R_UPPER)     cmd_next = CMD_EXT_RMT;
                else                                    cmd_next = CMD_OTHER;
            end else if (cmd_reg == CMD_OTHER) begin
                cmd_next = CMD_OTHER;
            end else begin
                priority if (off <= id_digits) begin
                    id_next  = {id_reg[27:0], hex.value};
                    err_next = err_reg || hex.bad;
                end else if (off == id_digits + PW'(1)) begin
                    if (hex.value > 4'(MAX_DATA_BYTES)) begin
                        dlen_next = 4'(MAX_DATA_BYTES);
                        err_next  = 1'b1;
                    end else begin
                        dlen_next = hex.value;
                        err_next  = err_reg || hex.bad;
                    end
                end else if (cnt_reg < {dlen_reg, 1'b0}) begin
                    payload_next[{nib_idx, 2'b00} +: 4] =
                        payload_reg[{nib_idx, 2'b00} +: 4] | hex.value;
                    cnt_next = cnt_reg + 5'd1;
                    err_next = err_reg || hex.bad;
                end else begin
                    cnt_next = cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_en_reg      <= 1'b0;
            prefix_char_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXT_ENABLE:  ext_en_reg      <= cfg_wdata[0];
                CFG_PREFIX_CHAR: prefix_char_reg <= cfg_wdata;
                default:         ext_en_reg      <= ext_en_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            cmd_reg         <= CMD_IDLE;
            bus_reg         <= '0;
            id_reg          <= '0;
            dlen_reg        <= '0;
            payload_reg     <= '0;
            cnt_reg         <= '0;
            err_reg         <= 1'b0;
            prefix_seen_reg <= 1'b0;
        end else if (accept) begin
            pos_reg         <= pos_next;
            cmd_reg         <= cmd_next;
            bus_reg         <= bus_next;
            id_reg          <= id_next;
            dlen_reg        <= dlen_next;
            payload_reg     <= payload_next;
            cnt_reg         <= cnt_next;
            err_reg         <= err_next;
            prefix_seen_reg <= prefix_seen_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && res_valid_next;
            end
        end else if (accept && res_valid_next) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        end else if (accept && res_valid_next) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_reg.kind;
    assign m_can_id       = out_reg.can_id;
    assign m_is_extended  = out_reg.is_extended;
    assign m_is_remote    = out_reg.is_remote;
    assign m_data_len     = out_reg.data_len;
    assign m_payload      = out_reg.payload;
    assign m_bus_number   = out_reg.bus_number;
    assign m_format_error = out_reg.format_error;

endmodule

### rtl/core/slcan_checker.sv
// Port-level checker for the serial-line CAN parser, bound to its top level.
// Depends on slcan_pkg and slcan_ascii_frame_parser_macros.svh.
`include "slcan_ascii_frame_parser_macros.svh"

module slcan_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [28:0] m_can_id,
    input logic        m_is_extended,
    input logic        m_is_remote,
    input logic [3:0]  m_data_len,
    input logic [63:0] m_payload,
    input logic [3:0]  m_bus_number,
    input logic        m_format_error
);
    import slcan_pkg::*;

    `SLCAN_ASSERT_SAME(a_nonframe_zero, aclk, aresetn,
        m_valid && m_result_kind != KIND_FRAME,
        m_can_id == '0 && !m_is_extended && !m_is_remote && m_data_len == '0 &&
        m_payload == '0 && m_bus_number == '0 && !m_format_error)
    `SLCAN_ASSERT_SAME(a_len_bound, aclk, aresetn,
        m_valid && m_result_kind == KIND_FRAME,
        m_data_len <= 4'(MAX_DATA_BYTES) && (m_data_len != '0 || m_payload == '0))
    `SLCAN_ASSERT_SAME(a_std_id_width, aclk, aresetn,
        m_valid && m_result_kind == KIND_FRAME && !m_is_extended,
        m_can_id[28:12] == '0)
    `SLCAN_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready,
        m_valid && $stable(m_result_kind) && $stable(m_payload) && $stable(m_can_id))

endmodule

bind slcan_ascii_frame_parser slcan_checker u_slcan_checker (.*);
